### hw/rtl/ofip_pkg.sv
`timescale 1ns / 1ps

package ofip_pkg;

    // Field widths
    localparam int CHAR_W  = 8;
    localparam int COUNT_W = 24;
    localparam int IDX_W   = 25;

    // Default width of the decimal accumulator
    localparam int INDEX_BITS_DEF = 24;

    // Stream widths: input is char plus three counts, output is three indexes
    localparam int S_TDATA_W = 80;
    localparam int M_TDATA_W = 80;
    localparam int M_TUSER_W = 2;

    // Number of index slots in one corner (position, texcoord, normal)
    localparam int SLOT_N = 3;

    // Character codes
    localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_VT    = 8'h0B;
    localparam logic [CHAR_W-1:0] CH_FF    = 8'h0C;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

    // Index limits and the "absent" marker
    localparam logic signed [IDX_W-1:0] IDX_NONE = -25'sd1;
    localparam int IDX_MAX = 16777215;
    localparam int IDX_MIN = -16777216;

    // One parsed result
    typedef struct packed {
        logic                    corner_valid;
        logic signed [IDX_W-1:0] position_index;
        logic signed [IDX_W-1:0] texcoord_index;
        logic signed [IDX_W-1:0] normal_index;
        logic                    value_overflow;
        logic                    line_end;
    } ofip_result_t;

endpackage

### hw/rtl/ofip_core.sv
`timescale 1ns / 1ps

module ofip_core #(
    parameter int INDEX_BITS = ofip_pkg::INDEX_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          accept,
    input  logic [ofip_pkg::CHAR_W-1:0]   char_code,
    input  logic [ofip_pkg::COUNT_W-1:0]  position_count,
    input  logic [ofip_pkg::COUNT_W-1:0]  texcoord_count,
    input  logic [ofip_pkg::COUNT_W-1:0]  normal_count,
    output logic                          res_valid,
    output ofip_pkg::ofip_result_t        res
);
    import ofip_pkg::*;

    // Product width for acc * 10 + digit, and signed width for index math
    localparam int MW = INDEX_BITS + 4;
    localparam int CW = ((INDEX_BITS > COUNT_W) ? INDEX_BITS : COUNT_W) + 2;
    localparam logic [MW-1:0] ACC_LIMIT = {4'b0000, {INDEX_BITS{1'b1}}};
    localparam logic signed [CW-1:0] V_MAX = CW'(IDX_MAX);
    localparam logic signed [CW-1:0] V_MIN = CW'(IDX_MIN);

    // Parser state
    logic [INDEX_BITS-1:0]   acc_reg, acc_next;
    logic                    neg_reg, neg_next;
    logic [1:0]              slot_reg, slot_next;
    logic signed [IDX_W-1:0] vals_reg [SLOT_N];
    logic signed [IDX_W-1:0] vals_next [SLOT_N];
    logic                    pending_reg, pending_next;
    logic                    ovf_reg, ovf_next;

    // Character classes
    logic                    is_digit, is_minus, is_slash, is_end, is_space;
    logic [CHAR_W-1:0]       digit_off;
    logic [MW-1:0]           acc_wide, prod;

    // Field close
    logic [1:0]              slot_eff;
    logic [COUNT_W-1:0]      cnt_sel;
    logic signed [CW-1:0]    v_raw;
    logic signed [IDX_W-1:0] v_clamp;
    logic                    v_ovf;
    logic signed [IDX_W-1:0] vals_close [SLOT_N];

    assign is_digit = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
    assign is_minus = (char_code == CH_MINUS);
    assign is_slash = (char_code == CH_SLASH);
    assign is_end   = (char_code == CH_NUL) || (char_code == CH_LF) || (char_code == CH_CR);
    assign is_space = (char_code == CH_SPACE) || (char_code == CH_TAB)
                   || (char_code == CH_VT) || (char_code == CH_FF);

    // Decimal step: acc * 10 + digit by shift and add
    assign digit_off = char_code - CH_ZERO;
    assign acc_wide  = {4'b0000, acc_reg};
    assign prod      = (acc_wide << 3) + (acc_wide << 1) + MW'(digit_off[3:0]);

    // Closing a field: pick the slot count, make the index, clamp it
    always_comb
    begin
        slot_eff = (slot_reg == 2'd3) ? 2'd0 : slot_reg;
        unique case (slot_eff)
            2'd0:    cnt_sel = position_count;
            2'd1:    cnt_sel = texcoord_count;
            default: cnt_sel = normal_count;
        endcase

        if (neg_reg && (acc_reg != '0))
        begin
            v_raw = $signed(CW'(cnt_sel)) - $signed(CW'(acc_reg));
        end
        else
        begin
            v_raw = $signed(CW'(acc_reg)) - $signed(CW'(1));
        end

        v_ovf = 1'b0;
        if (v_raw > V_MAX)
        begin
            v_clamp = V_MAX[IDX_W-1:0];
            v_ovf   = 1'b1;
        end
        else if (v_raw < V_MIN)
        begin
            v_clamp = V_MIN[IDX_W-1:0];
            v_ovf   = 1'b1;
        end
        else
        begin
            v_clamp = v_raw[IDX_W-1:0];
        end

        // Slots before the current one keep their value, later ones are absent
        for (int k = 0; k < SLOT_N; k++)
        begin
            if (2'(k) == slot_eff)
            begin
                vals_close[k] = v_clamp;
            end
            else if (2'(k) > slot_eff)
            begin
                vals_close[k] = IDX_NONE;
            end
            else
            begin
                vals_close[k] = vals_reg[k];
            end
        end
    end

    // Next state and result
    always_comb
    begin
        acc_next     = acc_reg;
        neg_next     = neg_reg;
        slot_next    = slot_reg;
        pending_next = pending_reg;
        ovf_next     = ovf_reg;
        for (int k = 0; k < SLOT_N; k++)
        begin
            vals_next[k] = vals_reg[k];
        end

        res_valid          = 1'b0;
        res.corner_valid   = 1'b0;
        res.position_index = IDX_NONE;
        res.texcoord_index = IDX_NONE;
        res.normal_index   = IDX_NONE;
        res.value_overflow = 1'b0;
        res.line_end       = is_end;

        if (accept)
        begin
            priority if (is_digit)
            begin
                if (prod > ACC_LIMIT)
                begin
                    acc_next = {INDEX_BITS{1'b1}};
                    ovf_next = 1'b1;
                end
                else
                begin
                    acc_next = prod[INDEX_BITS-1:0];
                end
                pending_next = 1'b1;
            end
            else if (is_minus)
            begin
                neg_next     = 1'b1;
                pending_next = 1'b1;
            end
            else if (is_slash)
            begin
                vals_next[slot_eff] = v_clamp;
                ovf_next     = ovf_reg | v_ovf;
                acc_next     = '0;
                neg_next     = 1'b0;
                slot_next    = (slot_reg >= 2'd2) ? 2'd0 : slot_reg + 2'd1;
                pending_next = 1'b1;
            end
            else if (is_end || is_space)
            begin
                if (pending_reg)
                begin
                    res_valid          = 1'b1;
                    res.corner_valid   = 1'b1;
                    res.position_index = vals_close[0];
                    res.texcoord_index = vals_close[1];
                    res.normal_index   = vals_close[2];
                    res.value_overflow = ovf_reg | v_ovf;
                end
                else if (is_end)
                begin
                    res_valid = 1'b1;
                end

                // Any emission returns the parser to its idle state
                if (pending_reg || is_end)
                begin
                    acc_next     = '0;
                    neg_next     = 1'b0;
                    slot_next    = 2'd0;
                    pending_next = 1'b0;
                    ovf_next     = 1'b0;
                    for (int k = 0; k < SLOT_N; k++)
                    begin
                        vals_next[k] = IDX_NONE;
                    end
                end
            end
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg     <= '0;
            neg_reg     <= 1'b0;
            slot_reg    <= 2'd0;
            pending_reg <= 1'b0;
            ovf_reg     <= 1'b0;
            for (int k = 0; k < SLOT_N; k++)
            begin
                vals_reg[k] <= IDX_NONE;
            end
        end
        else
        begin
            acc_reg     <= acc_next;
            neg_reg     <= neg_next;
            slot_reg    <= slot_next;
            pending_reg <= pending_next;
            ovf_reg     <= ovf_next;
            for (int k = 0; k < SLOT_N; k++)
            begin
                vals_reg[k] <= vals_next[k];
            end
        end
    end

endmodule

### hw/rtl/ofip_out_skid.sv
`timescale 1ns / 1ps

module ofip_out_skid (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  ofip_pkg::ofip_result_t in_data,
    output logic                   out_valid,
    input  logic                   out_ready,
    output ofip_pkg::ofip_result_t out_data
);
    import ofip_pkg::*;

    // Output stage plus one spare entry; ready comes straight from a flop
    logic         out_valid_reg, out_valid_next;
    logic         spare_valid_reg, spare_valid_next;
    ofip_result_t out_data_reg, out_data_next;
    ofip_result_t spare_data_reg, spare_data_next;
    logic         push, pop;

    assign in_ready  = !spare_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign push      = in_valid && !spare_valid_reg;
    assign pop       = out_valid_reg && out_ready;

    // Refill the output stage from the spare first, then from the input
    always_comb
    begin
        out_valid_next   = out_valid_reg;
        spare_valid_next = spare_valid_reg;
        out_data_next    = out_data_reg;
        spare_data_next  = spare_data_reg;
        if (pop || !out_valid_reg)
        begin
            if (spare_valid_reg)
            begin
                out_valid_next   = 1'b1;
                out_data_next    = spare_data_reg;
                spare_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = push;
                out_data_next  = in_data;
            end
        end
        else if (push)
        begin
            spare_valid_next = 1'b1;
            spare_data_next  = in_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg   <= 1'b0;
            spare_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg   <= out_valid_next;
            spare_valid_reg <= spare_valid_next;
        end
    end

    // Payload needs no reset
    always_ff @(posedge clk)
    begin
        out_data_reg   <= out_data_next;
        spare_data_reg <= spare_data_next;
    end

endmodule

### hw/rtl/obj_face_index_parser_unit.sv
`timescale 1ns / 1ps

// Channel | Dir | Signals                          | Carries
// s_*     | in  | tvalid tready tdata[79:0]        | one face-line character plus counts
// m_*     | out | tvalid tready tdata tuser tlast  | one finished corner or line-end marker
//
// One character is taken per cycle, every cycle, as long as the output buffer has room.
// A result is formed from the character that closes it and registered in the output buffer before it appears on m_*.
// s_tready comes from the occupancy flop of a two-entry output buffer; it drops only
// when both entries hold results that downstream has not taken.
// rst_n clears the parser to an empty token and empties the output buffer.
module obj_face_index_parser_unit #(
    parameter int INDEX_BITS = ofip_pkg::INDEX_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // [7:0] char_code, [31:8] position_count, [55:32] texcoord_count,
    // [79:56] normal_count
    input  logic [ofip_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [24:0] position_index, [49:25] texcoord_index, [74:50] normal_index,
    // [79:75] zero
    output logic [ofip_pkg::M_TDATA_W-1:0]   m_tdata,
    // [0] corner_valid, [1] value_overflow
    output logic [ofip_pkg::M_TUSER_W-1:0]   m_tuser,
    output logic                             m_tlast
);
    import ofip_pkg::*;

    logic         accept;
    logic         res_valid;
    ofip_result_t res;
    ofip_result_t out_res;

    // Request accepted when the buffer has room
    assign accept = s_tvalid && s_tready;

    ofip_core #(
        .INDEX_BITS (INDEX_BITS)
    ) u_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (accept),
        .char_code      (s_tdata[7:0]),
        .position_count (s_tdata[31:8]),
        .texcoord_count (s_tdata[55:32]),
        .normal_count   (s_tdata[79:56]),
        .res_valid      (res_valid),
        .res            (res)
    );

    ofip_out_skid u_out_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (res_valid),
        .in_ready  (s_tready),
        .in_data   (res),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_res)
    );

    // Output packing
    assign m_tdata = {5'b00000, out_res.normal_index, out_res.texcoord_index,
                      out_res.position_index};
    assign m_tuser = {out_res.value_overflow, out_res.corner_valid};
    assign m_tlast = out_res.line_end;

endmodule
